// ----- rtl/khpm_pkg.sv -----
// Shared types and constants for the kernel heap page mapper.
// Used by the top level, the port checker and the testbench result checker.
`default_nettype none

package khpm_pkg;

    // Frame pool and request limits
    localparam int FRAME_COUNT    = 1048576;
    localparam int MAX_GROW_PAGES = 63;

    // Page and address layout
    localparam int          PAGE_SHIFT     = 12;
    localparam logic [31:0] KERNEL_TOP     = 32'h4000_0000;
    localparam logic [31:0] ENTRY_BASE     = 32'hFFC0_0000;
    localparam logic [31:0] ENTRY_PRESENT  = 32'h0000_0001;
    localparam logic [31:0] ENTRY_WRITE    = 32'h0000_0002;
    localparam logic [30:0] HEAP_LIMIT_RST = 31'h4000_0000;

    // Bitmap held as 32-bit words, one bit per frame
    localparam int WORD_BITS = 32;
    localparam int WORDS     = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS = FRAME_COUNT - (WORDS - 1) * WORD_BITS;
    localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORDS - 1);
    // frames past the pool in the last word count as used
    localparam logic [31:0] LAST_MASK = 32'((64'd1 << LAST_BITS) - 64'd1);

    // Configuration register indexes
    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_GROW  = 2'd0,
        OP_MAP   = 2'd1,
        OP_ALLOC = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_MAPPED     = 3'd0,
        KIND_GROW_DONE  = 3'd1,
        KIND_ALLOCATED  = 3'd2,
        KIND_NO_VSPACE  = 3'd3,
        KIND_NO_FRAME   = 3'd4,
        KIND_NOT_KERNEL = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MAP_RD,
        ST_MAP_WR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [5:0]  page_count;
        logic [31:0] virtual_address;
        logic [31:0] physical_address;
        logic [11:0] map_flags;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] virtual_address_res;
        logic [31:0] frame_address;
        logic [31:0] entry_address;
        logic [31:0] entry_value;
        logic [17:0] chunk_size;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

// ----- rtl/kernel_heap_page_mapper.sv -----
// Kernel heap page mapper top level: free-frame bitmap in one RAM, heap pointer.
// Depends on khpm_pkg and khpm_ram.
// Allocate: bitmap words are read and checked in turn from the lowest non-full word, then the result is emitted.
// Map: the result is emitted directly, or after the frame bit is read, modified and written back.
// Grow: per page one frame search as above and one emitted mapping, then the final result.
// Reset: a clearing pass writes all 32768 bitmap words (one per cycle) before input is taken.
`default_nettype none

module kernel_heap_page_mapper (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request channel
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire khpm_pkg::t_in i_in,
    // result channel
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output khpm_pkg::t_out     o_out,
    // configuration write channel
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [30:0]   i_cfg_data
);

    localparam int WIDX = khpm_pkg::WIDX;

    khpm_pkg::t_state  r_state,     n_state;
    logic [WIDX-1:0]   r_low,       n_low;
    logic [WIDX-1:0]   r_clr,       n_clr;
    logic [31:0]       r_hp,        n_hp;
    logic [30:0]       r_limit,     n_limit;
    khpm_pkg::t_in     r_in,        n_in;
    logic              r_grow,      n_grow;
    logic [5:0]        r_left,      n_left;
    logic [31:0]       r_base,      n_base;
    khpm_pkg::t_out    r_pend,      n_pend;
    logic              r_out_valid, n_out_valid;
    khpm_pkg::t_out    r_out,       n_out;

    // bitmap RAM port signals
    logic              ram_we;
    logic [WIDX-1:0]   ram_waddr;
    logic [31:0]       ram_wdata;
    logic [WIDX-1:0]   ram_raddr;
    logic [31:0]       ram_rdata;

    khpm_ram #(
        .WIDTH (32),
        .DEPTH (khpm_pkg::WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Lowest free bit of the scanned word
    logic [31:0] scan_word;
    logic [31:0] scan_free;
    logic [31:0] scan_onehot;
    logic [4:0]  scan_bit;
    logic        scan_full;
    logic [31:0] scan_fa;

    always_comb begin
        scan_word   = ram_rdata |
                      ~((r_low == khpm_pkg::LAST_WORD) ? khpm_pkg::LAST_MASK : 32'hFFFF_FFFF);
        scan_free   = ~scan_word;
        scan_onehot = scan_free & (~scan_free + 32'd1);
        scan_full   = &scan_word;
        scan_bit    = '0;
        for (int b = 0; b < 32; b++) begin
            if (scan_onehot[b]) begin
                scan_bit = scan_bit | 5'(b);
            end
        end
        scan_fa = 32'({r_low, scan_bit}) << khpm_pkg::PAGE_SHIFT;
    end

    // Frame named by a map request
    logic [19:0]     map_frame;
    logic            map_in_pool;
    logic [WIDX-1:0] map_word;
    logic [31:0]     map_mask;

    assign map_frame   = r_in.physical_address[31:12];
    assign map_in_pool = {1'b0, i_in.physical_address[31:12]} < 21'(khpm_pkg::FRAME_COUNT);
    assign map_word    = map_frame[5 +: WIDX];
    assign map_mask    = 32'd1 << map_frame[4:0];

    // Grow limit check on the incoming request
    logic [32:0] grow_end;
    logic        grow_bad;

    assign grow_end = {1'b0, r_hp} + {15'd0, i_in.page_count, 12'd0};
    assign grow_bad = ({1'b0, i_in.page_count} > 7'(khpm_pkg::MAX_GROW_PAGES)) ||
                      (grow_end > {2'b00, r_limit});

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_clr       = r_clr;
        n_hp        = r_hp;
        n_limit     = r_limit;
        n_in        = r_in;
        n_grow      = r_grow;
        n_left      = r_left;
        n_base      = r_base;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_low;
        ram_wdata   = '0;
        ram_raddr   = r_low;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            khpm_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + WIDX'(1);
                if (r_clr == khpm_pkg::LAST_WORD) begin
                    n_state = khpm_pkg::ST_IDLE;
                end
            end

            khpm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_in   = i_in;
                    n_pend = '0;
                    n_pend.last = 1'b1;
                    case (i_in.operation)
                        khpm_pkg::OP_ALLOC: begin
                            n_grow  = 1'b0;
                            n_state = khpm_pkg::ST_SCAN_RD;
                        end
                        khpm_pkg::OP_MAP: begin
                            n_pend.virtual_address_res = i_in.virtual_address;
                            n_pend.frame_address       = i_in.physical_address;
                            if (i_in.virtual_address > khpm_pkg::KERNEL_TOP) begin
                                n_pend.kind = khpm_pkg::KIND_NOT_KERNEL;
                                n_state     = khpm_pkg::ST_EMIT;
                            end else begin
                                n_pend.kind          = khpm_pkg::KIND_MAPPED;
                                n_pend.entry_address = khpm_pkg::ENTRY_BASE |
                                    {10'd0, i_in.virtual_address[31:12], 2'b00};
                                n_pend.entry_value   = i_in.physical_address |
                                    khpm_pkg::ENTRY_PRESENT | khpm_pkg::ENTRY_WRITE |
                                    {20'd0, i_in.map_flags};
                                n_state = map_in_pool ? khpm_pkg::ST_MAP_RD
                                                      : khpm_pkg::ST_EMIT;
                            end
                        end
                        khpm_pkg::OP_GROW: begin
                            n_base = r_hp;
                            n_left = i_in.page_count;
                            n_grow = 1'b1;
                            if (grow_bad) begin
                                n_pend.kind                = khpm_pkg::KIND_NO_VSPACE;
                                n_pend.virtual_address_res = r_hp;
                                n_state                    = khpm_pkg::ST_EMIT;
                            end else if (i_in.page_count == 6'd0) begin
                                n_pend.kind                = khpm_pkg::KIND_GROW_DONE;
                                n_pend.virtual_address_res = r_hp;
                                n_state                    = khpm_pkg::ST_EMIT;
                            end else begin
                                n_state = khpm_pkg::ST_SCAN_RD;
                            end
                        end
                        default: begin
                            // unused code: dropped without a result
                            n_state = khpm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            khpm_pkg::ST_SCAN_RD: begin
                ram_raddr = r_low;
                n_state   = khpm_pkg::ST_SCAN_CHK;
            end

            khpm_pkg::ST_SCAN_CHK: begin
                n_pend = '0;
                if (scan_full) begin
                    if (r_low == khpm_pkg::LAST_WORD) begin
                        // pool exhausted
                        n_pend.kind                = khpm_pkg::KIND_NO_FRAME;
                        n_pend.virtual_address_res = r_grow ? r_hp : 32'd0;
                        n_pend.last                = 1'b1;
                        n_state                    = khpm_pkg::ST_EMIT;
                    end else begin
                        n_low   = r_low + WIDX'(1);
                        n_state = khpm_pkg::ST_SCAN_RD;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_low;
                    ram_wdata = ram_rdata | scan_onehot;
                    n_pend.frame_address = scan_fa;
                    n_state   = khpm_pkg::ST_EMIT;
                    if (!r_grow) begin
                        n_pend.kind = khpm_pkg::KIND_ALLOCATED;
                        n_pend.last = 1'b1;
                    end else begin
                        // heap page: map the new frame at the heap pointer
                        n_pend.virtual_address_res = r_hp;
                        if (r_hp > khpm_pkg::KERNEL_TOP) begin
                            n_pend.kind = khpm_pkg::KIND_NOT_KERNEL;
                        end else begin
                            n_pend.kind          = khpm_pkg::KIND_MAPPED;
                            n_pend.entry_address = khpm_pkg::ENTRY_BASE |
                                                   {10'd0, r_hp[31:12], 2'b00};
                            n_pend.entry_value   = scan_fa | khpm_pkg::ENTRY_PRESENT |
                                                   khpm_pkg::ENTRY_WRITE;
                        end
                        n_hp   = r_hp + 32'd4096;
                        n_left = r_left - 6'd1;
                    end
                end
            end

            khpm_pkg::ST_MAP_RD: begin
                ram_raddr = map_word;
                n_state   = khpm_pkg::ST_MAP_WR;
            end

            khpm_pkg::ST_MAP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = map_word;
                ram_wdata = ram_rdata | map_mask;
                n_state   = khpm_pkg::ST_EMIT;
            end

            khpm_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    if (r_pend.last) begin
                        n_state = khpm_pkg::ST_IDLE;
                    end else if (r_left == 6'd0) begin
                        n_pend                     = '0;
                        n_pend.kind                = khpm_pkg::KIND_GROW_DONE;
                        n_pend.virtual_address_res = r_base;
                        n_pend.chunk_size          = {r_in.page_count, 12'd0};
                        n_pend.last                = 1'b1;
                    end else begin
                        n_state = khpm_pkg::ST_SCAN_RD;
                    end
                end
            end

            default: begin
                n_state = khpm_pkg::ST_IDLE;
            end
        endcase

        // register writes: the host must issue them only while no request is in progress (not enforced)
        if (i_cfg_valid) begin
            case (i_cfg_index)
                khpm_pkg::CFG_HEAP_START: n_hp    = {1'b0, i_cfg_data};
                khpm_pkg::CFG_HEAP_LIMIT: n_limit = i_cfg_data;
                default:                  n_limit = r_limit;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= khpm_pkg::ST_CLEAR;
            r_low       <= '0;
            r_clr       <= '0;
            r_hp        <= '0;
            r_limit     <= khpm_pkg::HEAP_LIMIT_RST;
            r_grow      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_clr       <= n_clr;
            r_hp        <= n_hp;
            r_limit     <= n_limit;
            r_grow      <= n_grow;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_base <= n_base;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != khpm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/khpm_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the frame bitmap words.
`default_nettype none

module khpm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-cycle collision
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/khpm_checker.sv -----
// Port-level checks for the kernel heap page mapper, bound to the top level.
// Depends on khpm_pkg for the payload types and result kinds.
`default_nettype none

module khpm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire khpm_pkg::t_in  i_in,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire khpm_pkg::t_out o_out
);

    // no result is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // a request with a real opcode keeps the block busy the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_in.operation == khpm_pkg::OP_GROW || i_in.operation == khpm_pkg::OP_MAP ||
         i_in.operation == khpm_pkg::OP_ALLOC)
        |=> o_in_stall)
        else $error("request accepted without going busy");

    // only heap page mappings come ahead of the final result
    a_mid_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |->
        (o_out.kind == khpm_pkg::KIND_MAPPED || o_out.kind == khpm_pkg::KIND_NOT_KERNEL))
        else $error("unexpected kind before the final result");

endmodule

bind kernel_heap_page_mapper khpm_checker u_khpm_checker (.*);

`default_nettype wire

// ----- tb/sv/khpm_checker.sv -----
// Result checker for the kernel heap page mapper: watches all three channels,
// keeps its own frame bitmap and heap pointer, and compares every result transfer.
// Depends on khpm_pkg for payload types, operation and result codes, and address constants.
`timescale 1ns / 1ps

module khpm_result_check
    import khpm_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  wire t_in           i_in,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire t_out          i_out,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [30:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic [31:0] PAGE_BYTES  = 32'd1 << PAGE_SHIFT;
    localparam logic [31:0] PAGE_MASK   = ~(PAGE_BYTES - 32'd1);
    localparam int          ENTRY_SHIFT = 10;
    localparam int          PRINT_LIMIT = 32;

    // Predicted block state
    bit          frame_used [FRAME_COUNT];
    int          lowest_free;
    logic [31:0] heap_brk;
    logic [30:0] heap_ceiling;

    // Results still owed by the block, oldest first
    t_out        owed_results [$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at %0t ns: %s got %h want %h", $time, field, got, want);
        fail_count++;
    endtask

    function automatic t_out make_result(input t_kind kind, input logic [31:0] va,
                                         input logic [31:0] fa, input logic [31:0] ea,
                                         input logic [31:0] ev, input logic [17:0] size,
                                         input logic last);
        t_out res;
        res.kind                = kind;
        res.virtual_address_res = va;
        res.frame_address       = fa;
        res.entry_address       = ea;
        res.entry_value         = ev;
        res.chunk_size          = size;
        res.last                = last;
        return res;
    endfunction

    // Frames only ever become used, so the lowest free frame never moves down
    function automatic bit claim_lowest_frame(output logic [31:0] frame);
        while (lowest_free < FRAME_COUNT && frame_used[lowest_free])
            lowest_free++;
        if (lowest_free >= FRAME_COUNT)
            return 1'b0;
        frame_used[lowest_free] = 1'b1;
        frame = 32'(lowest_free);
        return 1'b1;
    endfunction

    // One mapping: entry write inside kernel space, refusal above it
    function automatic void predict_mapping(input logic [31:0] va, input logic [31:0] pa,
                                            input logic [11:0] flags, input logic last);
        logic [31:0] frame;
        if (va > KERNEL_TOP) begin
            owed_results.push_back(make_result(KIND_NOT_KERNEL, va, pa, '0, '0, '0, last));
        end else begin
            owed_results.push_back(make_result(KIND_MAPPED, va, pa,
                ENTRY_BASE | ((va & PAGE_MASK) >> ENTRY_SHIFT),
                pa | ENTRY_PRESENT | ENTRY_WRITE | {20'd0, flags}, '0, last));
            frame = pa >> PAGE_SHIFT;
            if (frame < FRAME_COUNT)
                frame_used[frame] = 1'b1;
        end
    endfunction

    // Heap growth: limit check, then one frame and one mapping per page
    function automatic void predict_growth(input logic [5:0] pages);
        logic [31:0] base;
        logic [31:0] frame;
        logic [63:0] reach;
        int          page;
        base  = heap_brk;
        reach = 64'(heap_brk) + 64'(pages) * 64'(PAGE_BYTES);
        if (pages > MAX_GROW_PAGES || reach > 64'(heap_ceiling)) begin
            owed_results.push_back(make_result(KIND_NO_VSPACE, heap_brk, '0, '0, '0, '0, 1'b1));
            return;
        end
        for (page = 0; page < int'(pages); page++) begin
            if (!claim_lowest_frame(frame)) begin
                owed_results.push_back(make_result(KIND_NO_FRAME, heap_brk, '0, '0, '0, '0,
                                                   1'b1));
                return;
            end
            predict_mapping(heap_brk, frame << PAGE_SHIFT, '0, 1'b0);
            heap_brk += PAGE_BYTES;
        end
        owed_results.push_back(make_result(KIND_GROW_DONE, base, '0, '0, '0,
                                           18'(32'(pages) << PAGE_SHIFT), 1'b1));
    endfunction

    function automatic void predict_request(input t_in req);
        logic [31:0] frame;
        case (req.operation)
            OP_ALLOC: begin
                if (claim_lowest_frame(frame))
                    owed_results.push_back(make_result(KIND_ALLOCATED, '0, frame << PAGE_SHIFT,
                                                       '0, '0, '0, 1'b1));
                else
                    owed_results.push_back(make_result(KIND_NO_FRAME, '0, '0, '0, '0, '0,
                                                       1'b1));
            end
            OP_MAP: begin
                predict_mapping(req.virtual_address, req.physical_address, req.map_flags, 1'b1);
            end
            OP_GROW: begin
                predict_growth(req.page_count);
            end
            default: ; // unused code: the block drops it
        endcase
    endfunction

    task automatic check_result(input t_out got);
        t_out want;
        if (owed_results.size() == 0) begin
            report_mismatch("unexpected result, kind", 32'(got.kind), '0);
            return;
        end
        want = owed_results.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.virtual_address_res != want.virtual_address_res)
            report_mismatch("virtual_address_res", got.virtual_address_res,
                            want.virtual_address_res);
        if (got.frame_address != want.frame_address)
            report_mismatch("frame_address", got.frame_address, want.frame_address);
        if (got.entry_address != want.entry_address)
            report_mismatch("entry_address", got.entry_address, want.entry_address);
        if (got.entry_value != want.entry_value)
            report_mismatch("entry_value", got.entry_value, want.entry_value);
        if (got.chunk_size != want.chunk_size)
            report_mismatch("chunk_size", 32'(got.chunk_size), 32'(want.chunk_size));
        if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // Register writes, request transfers and result transfers, in that order per edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_used[f])
                frame_used[f] = 1'b0;
            lowest_free  = 0;
            heap_brk     = '0;
            heap_ceiling = HEAP_LIMIT_RST;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HEAP_START)
                    heap_brk = {1'b0, i_cfg_data};
                else
                    heap_ceiling = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                predict_request(i_in);
            if (i_out_valid && !i_out_stall)
                check_result(i_out);
        end
        o_pending <= owed_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the kernel heap page mapper testbench: clock, reset, request and register
// stimulus, result-side stalls and the verdict. Depends on khpm_pkg, khpm_checker, the RTL.
`timescale 1ns / 1ps

module testbench;
    import khpm_pkg::*;

    localparam int         CYCLE_LIMIT = 8_000_000;
    localparam int         LONG_HOLD   = 600;
    localparam int         SETTLE      = 16;
    localparam int         DRAIN_TAIL  = 64;
    localparam int         PHASE_ITEMS = 80;
    localparam int         PHASES      = 5;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [30:0] REG_MAX    = 31'h7FFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_req;
    logic        out_valid;
    logic        out_stall;
    t_out        out_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [30:0] cfg_data;
    int          fail_count;
    int          pending;
    bit          long_hold_go;

    kernel_heap_page_mapper dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    khpm_result_check mapper_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_res),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, generous against the clearing pass and worst stalls
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    function automatic t_in build_request(input t_op op, input logic [5:0] pages,
                                          input logic [31:0] va, input logic [31:0] pa,
                                          input logic [11:0] flags);
        t_in req;
        req.operation        = op;
        req.page_count       = pages;
        req.virtual_address  = va;
        req.physical_address = pa;
        req.map_flags        = flags;
        return req;
    endfunction

    function automatic t_in random_request();
        t_in req;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req.operation = OP_GROW;
        else if (pick < 65)
            req.operation = OP_MAP;
        else if (pick < 95)
            req.operation = OP_ALLOC;
        else
            req.operation = t_op'(OP_RESERVED);
        req.page_count = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 6));
        case ($urandom_range(0, 3))
            0: req.virtual_address = $urandom;
            1: req.virtual_address = KERNEL_TOP + 32'($urandom_range(0, 2)) - 32'd1;
            default: req.virtual_address = 32'($urandom_range(0, KERNEL_TOP));
        endcase
        // low frames collide with the allocator, the rest land anywhere
        req.physical_address = ($urandom_range(0, 1) == 0) ? $urandom
                             : {20'($urandom_range(0, 4095)), 12'($urandom)};
        req.map_flags = 12'($urandom);
        return req;
    endfunction

    // One request transfer; valid stays up on return so back-to-back items need no gap
    task automatic push_request(input t_in req);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_heap(input logic [30:0] heap_base, input logic [30:0] heap_top);
        write_reg(CFG_HEAP_START, heap_base);
        write_reg(CFG_HEAP_LIMIT, heap_top);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every owed result, then let the block settle
    task automatic wait_drained(input int tail);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off while requests keep coming
    initial begin : result_sink
        int span;
        bit long_hold_seen;
        out_stall      = 1'b0;
        long_hold_seen = 1'b0;
        @(negedge clk);
        forever begin
            if (long_hold_go && !long_hold_seen) begin
                long_hold_seen = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 2) == 0);
                span = pick_gap();
                repeat (span) @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          counted;
        t_in         req;
        logic [30:0] heap_base;
        logic [30:0] heap_top;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_req       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_HEAP_START;
        cfg_data     = '0;
        long_hold_go = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: heap at zero, limit at kernel top
        push_request(build_request(OP_ALLOC, 6'd0, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd0, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd1, '0, '0, '0));
        push_request(build_request(OP_MAP, 6'd0, KERNEL_TOP, 32'h0000_2000, '0));
        push_request(build_request(OP_ALLOC, 6'd0, '0, '0, '0));
        push_request(build_request(OP_MAP, 6'd0, KERNEL_TOP + 32'd1, 32'h0000_5000, 12'h3A5));
        push_request(build_request(OP_MAP, 6'd63, '1, '1, '1));
        push_request(build_request(OP_MAP, 6'd0, KERNEL_TOP - 32'd1, '1, '1));
        push_request(build_request(OP_MAP, 6'd0, '0, '0, '0));
        push_request(build_request(t_op'(OP_RESERVED), 6'd5, '1, '1, '1));
        push_request(build_request(OP_GROW, 6'd63, '0, '0, '0));
        push_request(build_request(OP_ALLOC, 6'd0, '0, '0, '0));
        wait_drained(SETTLE);

        // Heap crossing the kernel top: late pages come back refused
        set_heap(31'h3FFF_C000, REG_MAX);
        push_request(build_request(OP_GROW, 6'd8, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd63, '0, '0, '0));
        wait_drained(SETTLE);

        // Limit reached exactly, then refused; empty grow still fits
        set_heap(31'h0001_0000, 31'h0001_A000);
        push_request(build_request(OP_GROW, 6'd10, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd1, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd0, '0, '0, '0));
        wait_drained(SETTLE);

        set_heap('0, '0);
        push_request(build_request(OP_GROW, 6'd0, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd1, '0, '0, '0));
        push_request(build_request(OP_ALLOC, 6'd0, '0, '0, '0));
        wait_drained(SETTLE);

        set_heap(REG_MAX, REG_MAX);
        push_request(build_request(OP_GROW, 6'd1, '0, '0, '0));
        push_request(build_request(OP_GROW, 6'd0, '0, '0, '0));
        wait_drained(SETTLE);

        // Random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    heap_base = 31'($urandom_range(0, 32'h3_FFFF)) << PAGE_SHIFT;
                    heap_top  = heap_base + (31'($urandom_range(64, 1024)) << PAGE_SHIFT);
                end
                1: begin
                    heap_base = 31'($urandom);
                    heap_top  = 31'($urandom);
                end
                2: begin
                    heap_base = 31'(KERNEL_TOP) - (31'($urandom_range(0, 40)) << PAGE_SHIFT);
                    heap_top  = REG_MAX;
                end
                3: begin
                    heap_base = '0;
                    heap_top  = HEAP_LIMIT_RST;
                end
                default: begin
                    heap_base = 31'($urandom_range(0, 32'h3_FFFF)) << PAGE_SHIFT;
                    heap_top  = heap_base + (31'($urandom_range(0, 200)) << PAGE_SHIFT);
                end
            endcase
            set_heap(heap_base, heap_top);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (phase == 2 && counted == 20)
                    long_hold_go = 1'b1;
                req = random_request();
                push_request(req);
                if (req.operation != t_op'(OP_RESERVED))
                    counted++;
            end
            wait_drained(SETTLE);
        end

        wait_drained(DRAIN_TAIL);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
